FILE: design/gtpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtpp_pkg
// Shared types, codes and sizes of the grammar table pushdown parser.
// ----------------------------------------------------------------------------
package gtpp_pkg;

  localparam int NUM_RULES    = 8;
  localparam int MAX_OPTIONS  = 8;
  localparam int MAX_ELEMENTS = 16;
  localparam int STACK_DEPTH  = 16;
  localparam int SEARCH_LIMIT = 1024;
  localparam int TRY_W        = 11;

  typedef enum logic [1:0] {
    OP_TOKEN     = 2'd0,
    OP_ELEMENT   = 2'd1,
    OP_LENGTH    = 2'd2,
    OP_OPT_COUNT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_WRITE    = 3'd0,
    ST_MATCH    = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_ERROR    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_CHECK,
    S_READ,
    S_ELEM,
    S_ADV,
    S_ADV_POP,
    S_ADV_WAIT,
    S_ALT,
    S_ALT_POP,
    S_SETTLE,
    S_RESTART,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic do_write;
    logic read_elem;
    logic push;
    logic pop;
    logic pos_inc;
    logic opt_inc;
    logic restart;
    logic set_expected;
    logic try_inc;
    logic load_out;
    status_t status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic fail;
    logic elem_is_rule;
    logic stack_full;
    logic kind_match;
    logic last_pos;
    logic last_opt;
    logic at_root;
    logic limit_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/gtpp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtpp_ctrl
// Sequencer that applies table writes and walks a token through descent, comparison and popping.
// ----------------------------------------------------------------------------
module gtpp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic                out_busy,
  input  wire gtpp_pkg::dp_stat_t  stat,
  output gtpp_pkg::ctrl_cmd_t      cmd,
  output logic                     idle
);
  import gtpp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.status = ST_WRITE;
    idle = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (stat.op != OP_TOKEN) begin
          cmd.do_write = 1'b1;
          state_next = S_DONE;
          cmd.status = ST_WRITE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.limit_hit) begin
          cmd.status = ST_ERROR;
          cmd.restart = 1'b1;
          state_next = S_DONE;
        end else if (stat.fail) begin
          cmd.try_inc = 1'b1;
          state_next = S_ALT;
        end else begin
          cmd.read_elem = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_ELEM;
      S_ELEM: begin
        if (stat.elem_is_rule) begin
          if (stat.stack_full) begin
            cmd.status = ST_OVERFLOW;
            cmd.restart = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.push = 1'b1;
            state_next = S_SETTLE;
          end
        end else begin
          cmd.set_expected = 1'b1;
          cmd.try_inc = 1'b1;
          state_next = stat.kind_match ? S_ADV : S_ALT;
        end
      end
      S_ADV: begin
        if (stat.last_pos) begin
          if (stat.at_root) begin
            cmd.status = ST_COMPLETE;
            cmd.restart = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.pop = 1'b1;
            state_next = S_ADV_POP;
          end
        end else begin
          cmd.pos_inc = 1'b1;
          cmd.status = ST_MATCH;
          state_next = S_DONE;
        end
      end
      // The length table read is registered and lags the active rule.
      S_ADV_POP: state_next = S_ADV_WAIT;
      S_ADV_WAIT: state_next = S_ADV;
      S_ALT: begin
        if (stat.last_opt) begin
          if (stat.at_root) begin
            cmd.status = ST_ERROR;
            cmd.restart = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.pop = 1'b1;
            state_next = S_ALT_POP;
          end
        end else begin
          cmd.opt_inc = 1'b1;
          state_next = S_SETTLE;
        end
      end
      S_ALT_POP: state_next = S_ALT;
      S_SETTLE: state_next = S_CHECK;
      S_RESTART: state_next = S_DONE;
      S_DONE: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/gtpp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtpp_datapath
// Grammar tables, frame stack, active position registers and result register.
// ----------------------------------------------------------------------------
module gtpp_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [33:0]         in_data,
  input  wire logic [2:0]          start_rule,
  input  wire gtpp_pkg::ctrl_cmd_t cmd,
  output gtpp_pkg::dp_stat_t       stat,
  output logic [24:0]              out_data
);
  import gtpp_pkg::*;

  localparam int RW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int OW  = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
  localparam int PW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int LW  = $clog2(MAX_ELEMENTS + 1);
  localparam int NW  = $clog2(MAX_OPTIONS + 1);
  localparam int FW  = RW + OW + PW;

  // Captured item.
  op_t        op;
  logic [2:0] w_rule, w_opt;
  logic [3:0] w_pos;
  logic       w_isr;
  logic [7:0] w_val, kind;
  logic [4:0] w_cnt;

  logic [8:0]    elems   [NUM_RULES*MAX_OPTIONS*MAX_ELEMENTS];
  logic [LW-1:0] lens    [NUM_RULES*MAX_OPTIONS];
  logic [NW-1:0] counts  [NUM_RULES];
  logic [FW-1:0] frames  [STACK_DEPTH];

  logic [CW-1:0] fcount;
  logic [7:0]    arule;
  logic [7:0]    aopt;
  logic [7:0]    apos;
  logic [7:0]    expected;
  logic [8:0]    elem_q;
  logic [FW-1:0] frame_q;
  logic [LW-1:0] len_q;
  logic [TRY_W-1:0] tries;

  logic          rule_ok;
  logic [NW-1:0] cnt_now;
  logic [LW-1:0] len_now;

  assign rule_ok = ({24'd0, arule} < NUM_RULES);
  assign cnt_now = rule_ok ? counts[arule[RW-1:0]] : '0;
  assign len_now = (rule_ok && ({24'd0, aopt} < MAX_OPTIONS)) ? len_q : '0;

  always_comb begin
    stat.op           = op;
    stat.fail         = (cnt_now == '0) || ({24'd0, aopt} >= 32'(cnt_now))
                        || ({24'd0, apos} >= 32'(len_now));
    stat.elem_is_rule = elem_q[8];
    stat.stack_full   = (32'(fcount) >= STACK_DEPTH - 1);
    stat.kind_match   = (elem_q[7:0] == kind);
    stat.last_pos     = ({24'd0, apos} + 32'd1 >= 32'(len_now));
    stat.last_opt     = ({24'd0, aopt} + 32'd1 >= 32'(cnt_now));
    stat.at_root      = (fcount == '0);
    stat.limit_hit    = (32'(tries) >= SEARCH_LIMIT);
  end

  // Tables.
  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      if (op == OP_ELEMENT && {29'd0, w_rule} < NUM_RULES && {29'd0, w_opt} < MAX_OPTIONS
          && {28'd0, w_pos} < MAX_ELEMENTS)
        elems[{w_rule[RW-1:0], w_opt[OW-1:0], w_pos[PW-1:0]}] <= {w_isr, w_val};
      if (op == OP_LENGTH && {29'd0, w_rule} < NUM_RULES && {29'd0, w_opt} < MAX_OPTIONS)
        lens[{w_rule[RW-1:0], w_opt[OW-1:0]}] <=
          ({27'd0, w_cnt} > MAX_ELEMENTS) ? LW'(MAX_ELEMENTS) : LW'(w_cnt);
    end
    // The option length of the active rule is read every cycle.
    len_q <= lens[{arule[RW-1:0], aopt[OW-1:0]}];
    if (cmd.read_elem)
      elem_q <= elems[{arule[RW-1:0], aopt[OW-1:0], apos[PW-1:0]}];
    if (cmd.push)
      frames[fcount[SW-1:0]] <= {arule[RW-1:0], aopt[OW-1:0], apos[PW-1:0]};
    if (cmd.pop)
      frame_q <= frames[SW'(fcount - CW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RULES; i++) counts[i] <= '0;
    end else if (cmd.do_write && op == OP_OPT_COUNT && {29'd0, w_rule} < NUM_RULES) begin
      counts[w_rule[RW-1:0]] <=
        ({27'd0, w_cnt} > MAX_OPTIONS) ? NW'(MAX_OPTIONS) : NW'(w_cnt);
    end
  end

  // The popped frame is read into frame_q, then loaded into the active registers on the delayed pop flag.
  logic pop_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount   <= '0;
      arule    <= '0;
      aopt     <= '0;
      apos     <= '0;
      pop_d    <= 1'b0;
      tries    <= '0;
      expected <= '0;
    end else begin
      pop_d <= cmd.pop;
      if (cmd.capture) begin
        tries    <= '0;
        expected <= '0;
      end
      if (cmd.try_inc) tries <= tries + TRY_W'(1);
      if (cmd.set_expected) expected <= elem_q[7:0];
      if (cmd.push) begin
        fcount <= fcount + CW'(1);
        arule  <= elem_q[7:0];
        aopt   <= '0;
        apos   <= '0;
      end
      if (cmd.pop) fcount <= fcount - CW'(1);
      if (pop_d) begin
        arule <= 8'(frame_q[FW-1 -: RW]);
        aopt  <= 8'(frame_q[PW +: OW]);
        apos  <= 8'(frame_q[PW-1:0]);
      end
      if (cmd.pos_inc) apos <= apos + 8'd1;
      if (cmd.opt_inc) begin
        aopt <= aopt + 8'd1;
        apos <= '0;
      end
      if (cmd.restart) begin
        fcount <= '0;
        arule  <= 8'(start_rule);
        aopt   <= '0;
        apos   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= op_t'(in_data[1:0]);
      w_rule <= in_data[4:2];
      w_opt  <= in_data[7:5];
      w_pos  <= in_data[11:8];
      w_isr  <= in_data[12];
      w_val  <= in_data[20:13];
      w_cnt  <= in_data[25:21];
      kind   <= in_data[33:26];
    end
  end

  // Result held until the status code settles in the DONE state.
  status_t res_status;

  always_ff @(posedge clk) begin
    if (cmd.do_write || cmd.restart || cmd.pos_inc) res_status <= cmd.status;
    if (cmd.load_out)
      out_data <= {expected, apos[3:0], aopt[2:0], arule[2:0], 4'(fcount), res_status};
  end

endmodule

`default_nettype wire

FILE: design/grammar_table_pushdown_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grammar_table_pushdown_parser
// Table-driven LL parser with ordered alternatives and a return frame stack.
// ----------------------------------------------------------------------------
// One item is taken at a time. A table write is applied and its result is
// presented without a search. A token is matched against the element table
// by descending into subrules, popping after a finished option or out of a
// failed rule, and retrying options in order. The search is paced by the
// sequencer walking the single-port element table, the registered length
// table and the frame stack one access at a time. The result sits in an
// output register, so the next item is accepted while it waits to be taken.
module grammar_table_pushdown_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operation, rule_index, option_index, position_index, element_is_rule,
  // element_value, count_value, token_kind; zero pad
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status, stack_level, rule_now, option_now, position_now, expected_kind;
  // zero pad
  output logic [31:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);
  import gtpp_pkg::*;

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic        idle;
  logic [2:0]  start_rule;
  logic [24:0] out_data;

  assign s_tready  = idle;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'd0, out_data};

  always_ff @(posedge clk) begin
    if (rst) start_rule <= '0;
    else if (cfg_valid) start_rule <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  gtpp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready),
    .out_busy(m_tvalid && !m_tready), .stat(stat), .cmd(cmd), .idle(idle)
  );

  gtpp_datapath u_dp (
    .clk(clk), .rst(rst), .in_data(s_tdata[33:0]), .start_rule(start_rule),
    .cmd(cmd), .stat(stat), .out_data(out_data)
  );

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop)) else $error("push and pop together");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(m_tvalid && !m_tready)) else $error("result overwritten");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second item taken");

endmodule

`default_nettype wire
